// ===== sv/bfcrm_pkg.sv =====
// ----------------------------------------------------------------------------
// bfcrm_pkg: shared constants for the bale/flake counter and rate meter
// Widths of the counters, the rate constant and the serial datapath sizes.
// ----------------------------------------------------------------------------
package bfcrm_pkg;

  // Counter widths
  localparam int COUNT_BITS  = 32;
  localparam int FLAKE_BITS  = 16;

  // Fixed field widths of the channels
  localparam int COUNT_OUT_W = 32;
  localparam int FLAKE_OUT_W = 16;
  localparam int TIME_BITS   = 32;
  localparam int SESS_BITS   = 32;
  localparam int RATE_BITS   = 16;

  // Tenths of a bale per hour: 3600000 ms per hour times 10
  localparam int K_BITS                 = 26;
  localparam logic [K_BITS-1:0] K_TENTHS = K_BITS'(36000000);
  localparam int K_IDX_W                = $clog2(K_BITS);

  // Product of (session - 1) and the constant
  localparam int PROD_BITS = SESS_BITS + K_BITS;
  localparam int DIV_CNT_W = $clog2(RATE_BITS);

endpackage

// ===== sv/bfcrm_in_if.sv =====
// ----------------------------------------------------------------------------
// bfcrm_in_if: sample channel
// Valid/ready channel carrying one sensor sample per beat.
// ----------------------------------------------------------------------------
interface bfcrm_in_if
  import bfcrm_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 bale_level;
  logic                 flake_level;
  logic [TIME_BITS-1:0] time_ms;
  logic                 clear_bale;
  logic                 clear_year;
  logic                 clear_flakes;

  modport source (
    output valid, bale_level, flake_level, time_ms, clear_bale, clear_year, clear_flakes,
    input  ready
  );

  modport sink (
    input  valid, bale_level, flake_level, time_ms, clear_bale, clear_year, clear_flakes,
    output ready
  );
endinterface

// ===== sv/bfcrm_out_if.sv =====
// ----------------------------------------------------------------------------
// bfcrm_out_if: result channel
// Valid/ready channel carrying the counters and the rate, one beat per sample.
// ----------------------------------------------------------------------------
interface bfcrm_out_if
  import bfcrm_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [COUNT_OUT_W-1:0] bale_total;
  logic [COUNT_OUT_W-1:0] bale_year_total;
  logic [FLAKE_OUT_W-1:0] flakes_now;
  logic [FLAKE_OUT_W-1:0] flakes_last;
  logic [FLAKE_OUT_W-1:0] flakes_before_last;
  logic [RATE_BITS-1:0]   rate_tenths;
  logic                   bale_seen;
  logic                   flake_seen;

  modport source (
    output valid, bale_total, bale_year_total, flakes_now, flakes_last,
           flakes_before_last, rate_tenths, bale_seen, flake_seen,
    input  ready
  );

  modport sink (
    input  valid, bale_total, bale_year_total, flakes_now, flakes_last,
           flakes_before_last, rate_tenths, bale_seen, flake_seen,
    output ready
  );
endinterface

// ===== sv/bfcrm_mul.sv =====
// ----------------------------------------------------------------------------
// bfcrm_mul: bit-serial multiply by the tenths-per-hour constant
// Walks the constant LSB first, one shift-add per cycle, one per constant bit.
// ----------------------------------------------------------------------------
module bfcrm_mul
  import bfcrm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [SESS_BITS-1:0] mult_i,
  output logic                 done_o,
  output logic [PROD_BITS-1:0] prod_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [K_IDX_W-1:0]   cnt_q;
  logic [SESS_BITS-1:0] m_q;
  logic [SESS_BITS-1:0] hi_q;
  logic [K_BITS-1:0]    lo_q;
  logic [SESS_BITS:0]   sum;

  // add the multiplicand when the current constant bit is set
  assign sum = {1'b0, hi_q} + (K_TENTHS[cnt_q] ? {1'b0, m_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == K_IDX_W'(K_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q  <= mult_i;
      hi_q <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      hi_q <= sum[SESS_BITS:1];
      lo_q <= {sum[0], lo_q[K_BITS-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

// ===== sv/bfcrm_div.sv =====
// ----------------------------------------------------------------------------
// bfcrm_div: restoring divider with 16-bit saturated quotient
// Checks for overflow on load, then one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfcrm_div
  import bfcrm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [PROD_BITS-1:0] dividend_i,
  input  logic [TIME_BITS-1:0] divisor_i,
  output logic                 done_o,
  output logic [RATE_BITS-1:0] quot_o
);

  logic                 busy_q;
  logic                 done_q;
  logic                 sat_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [TIME_BITS-1:0] d_q;
  logic [TIME_BITS-1:0] r_q;
  logic [RATE_BITS-1:0] q_q;
  logic                 sat;
  logic [TIME_BITS:0]   trial;
  logic [TIME_BITS:0]   diff;
  logic                 ge;

  // quotient overflows 16 bits when the upper dividend reaches the divisor
  assign sat   = dividend_i[PROD_BITS-1:RATE_BITS] >=
                 (PROD_BITS - RATE_BITS)'(divisor_i);
  assign trial = {r_q, q_q[RATE_BITS-1]};
  assign diff  = trial - {1'b0, d_q};
  assign ge    = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !sat;
        done_q <= sat;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(RATE_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sat_q <= sat;
      d_q   <= divisor_i;
      r_q   <= dividend_i[RATE_BITS +: TIME_BITS];
      q_q   <= dividend_i[RATE_BITS-1:0];
    end else if (busy_q) begin
      r_q <= ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
      q_q <= {q_q[RATE_BITS-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = sat_q ? '1 : q_q;

endmodule

// ===== sv/bale_flake_counter_rate_meter_top.sv =====
// ----------------------------------------------------------------------------
// bale_flake_counter_rate_meter_top: bale and flake counter with rate meter
// Counts sensor edges per sample and reports counts and bales per hour.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one sensor sample per beat (two active-low levels, a ms
//   timestamp, three clear strobes); out_o returns one result beat per sample:
//   bale, year and flake counts, the rate in tenths of a bale per hour, and
//   flags for the edges counted. Clears act before edges; bale before flake.
//
// Sequence:
//   Without a new rate, an accepted sample goes straight to the emit step,
//   which loads the output register. A bale edge that starts a rate
//   computation runs the multiplier (one step per constant bit), the divider
//   load with the overflow check and the quotient bits, then stores the rate
//   and loads the output in the emit step. A saturating quotient skips the
//   quotient bits. Ready is high only while idle, so no new sample is taken
//   until the last one has left the emit step.
//
// Reset: all counters, the rate and the session clear; both previous sensor
//   levels read as released (high). No output beat is pending.
// Stall: a finished result sits in the output register. The next sample is
//   accepted and computed meanwhile; its beat then waits in the emit step,
//   with input ready low, until the receiver takes the first.
// ----------------------------------------------------------------------------
module bale_flake_counter_rate_meter_top
  import bfcrm_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  bfcrm_in_if.sink       in_i,
  bfcrm_out_if.source    out_o
);

  // State codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [FLAKE_BITS-1:0] FLAKE_MAX = '1;
  localparam logic [SESS_BITS-1:0]  SESS_MAX  = '1;

  logic [1:0]            state_q, state_d;

  // Block state
  logic                  prev_bale_q, prev_flake_q;
  logic [COUNT_BITS-1:0] bale_cnt_q, year_cnt_q;
  logic [FLAKE_BITS-1:0] fnow_q, fh0_q, fh1_q;
  logic [SESS_BITS-1:0]  sess_q;
  logic [TIME_BITS-1:0]  start_ms_q;
  logic [RATE_BITS-1:0]  rate_q;
  logic [TIME_BITS-1:0]  elapsed_q;
  logic                  bale_seen_q, flake_seen_q;

  // Next values computed on an accepted sample
  logic [COUNT_BITS-1:0] bale_cnt_d, year_cnt_d;
  logic [FLAKE_BITS-1:0] fnow_d, fh0_d, fh1_d;
  logic [SESS_BITS-1:0]  sess_d;
  logic [TIME_BITS-1:0]  start_ms_d;
  logic [RATE_BITS-1:0]  rate_d;
  logic [TIME_BITS-1:0]  elapsed_d;
  logic                  bale_edge, flake_edge, rate_go;

  // Output register
  logic                  out_valid_q;
  logic                  out_free;
  logic                  in_fire;

  // Serial units
  logic                  mul_done, div_done;
  logic [PROD_BITS-1:0]  prod;
  logic [RATE_BITS-1:0]  quot;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign bale_edge  = !prev_bale_q && in_i.bale_level;
  assign flake_edge = !prev_flake_q && in_i.flake_level;

  // Apply clears first, then the bale edge, then the flake edge.
  always_comb begin
    bale_cnt_d = in_i.clear_bale   ? '0 : bale_cnt_q;
    sess_d     = in_i.clear_bale   ? '0 : sess_q;
    start_ms_d = in_i.clear_bale   ? '0 : start_ms_q;
    rate_d     = in_i.clear_bale   ? '0 : rate_q;
    year_cnt_d = in_i.clear_year   ? '0 : year_cnt_q;
    fnow_d     = in_i.clear_flakes ? '0 : fnow_q;
    fh0_d      = in_i.clear_flakes ? '0 : fh0_q;
    fh1_d      = in_i.clear_flakes ? '0 : fh1_q;
    elapsed_d  = in_i.time_ms - start_ms_d;
    rate_go    = 1'b0;

    if (bale_edge) begin
      bale_cnt_d = bale_cnt_d + 1'b1;
      year_cnt_d = year_cnt_d + 1'b1;
      if (sess_d == '0) begin
        // first bale opens the session
        start_ms_d = in_i.time_ms;
        sess_d     = SESS_BITS'(1);
        rate_d     = '0;
      end else begin
        if (sess_d != SESS_MAX) begin
          sess_d = sess_d + 1'b1;
        end
        rate_go = (elapsed_d != '0);
        rate_d  = '0;
      end
      fh1_d  = fh0_d;
      fh0_d  = fnow_d;
      fnow_d = '0;
    end

    if (flake_edge && (fnow_d != FLAKE_MAX)) begin
      fnow_d = fnow_d + 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = rate_go ? ST_MUL : ST_EMIT;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      prev_bale_q  <= 1'b1;
      prev_flake_q <= 1'b1;
      bale_cnt_q   <= '0;
      year_cnt_q   <= '0;
      fnow_q       <= '0;
      fh0_q        <= '0;
      fh1_q        <= '0;
      sess_q       <= '0;
      start_ms_q   <= '0;
      rate_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        prev_bale_q  <= in_i.bale_level;
        prev_flake_q <= in_i.flake_level;
        bale_cnt_q   <= bale_cnt_d;
        year_cnt_q   <= year_cnt_d;
        fnow_q       <= fnow_d;
        fh0_q        <= fh0_d;
        fh1_q        <= fh1_d;
        sess_q       <= sess_d;
        start_ms_q   <= start_ms_d;
        rate_q       <= rate_d;
      end else if (state_q == ST_DIV && div_done) begin
        rate_q <= quot;
      end
      // Hold the beat until taken; load a new one when the slot frees.
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-sample payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      elapsed_q    <= elapsed_d;
      bale_seen_q  <= bale_edge;
      flake_seen_q <= flake_edge;
    end
    if (state_q == ST_EMIT && out_free) begin
      out_o.bale_total         <= COUNT_OUT_W'(bale_cnt_q);
      out_o.bale_year_total    <= COUNT_OUT_W'(year_cnt_q);
      out_o.flakes_now         <= FLAKE_OUT_W'(fnow_q);
      out_o.flakes_last        <= FLAKE_OUT_W'(fh0_q);
      out_o.flakes_before_last <= FLAKE_OUT_W'(fh1_q);
      out_o.rate_tenths        <= rate_q;
      out_o.bale_seen          <= bale_seen_q;
      out_o.flake_seen         <= flake_seen_q;
    end
  end

  assign out_o.valid = out_valid_q;

  // (session - 1) times tenths-per-hour
  bfcrm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire && rate_go),
    .mult_i  (sess_d - 1'b1),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // divide by elapsed milliseconds, saturate to 16 bits
  bfcrm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_MUL && mul_done),
    .dividend_i (prod),
    .divisor_i  (elapsed_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Serial units finish only in the state that waits for them
  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ST_MUL) else $error("multiplier done outside MUL");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV) else $error("divider done outside DIV");

  // A nonzero rate needs at least two bales in the session
  a_rate_session: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rate_q != '0) |-> (sess_q > SESS_BITS'(1))) else $error("rate without session");

  // A new beat only appears from the emit step
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_EMIT) else $error("beat not from emit");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: bale and flake counter with rate meter
// Sends sensor samples over the valid/ready channel, computes each expected
// tally in the bench, and checks every result beat field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bfcrm_pkg::*;

  // Run control
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned MAX_PRINTED  = 100;

  // 3600000 ms per hour, times 10 for tenths
  localparam logic [63:0] TENTHS_MS_PER_HOUR = 64'd36000000;

  // Receiver pacing styles
  typedef enum int {
    SINK_FREE,
    SINK_RANDOM,
    SINK_PATTERN,
    SINK_HEAVY
  } sink_mode_e;

  // One sensor sample as it travels on the input channel
  typedef struct packed {
    logic                 bale_level;
    logic                 flake_level;
    logic [TIME_BITS-1:0] time_ms;
    logic                 clear_bale;
    logic                 clear_year;
    logic                 clear_flakes;
  } sample_t;

  // One result beat: counts, history, rate and edge flags
  typedef struct packed {
    logic [COUNT_OUT_W-1:0] bale_total;
    logic [COUNT_OUT_W-1:0] bale_year_total;
    logic [FLAKE_OUT_W-1:0] flakes_now;
    logic [FLAKE_OUT_W-1:0] flakes_last;
    logic [FLAKE_OUT_W-1:0] flakes_before_last;
    logic [RATE_BITS-1:0]   rate_tenths;
    logic                   bale_seen;
    logic                   flake_seen;
  } tally_t;

  logic clk_i;
  logic rst_ni;

  bfcrm_in_if  smp ();
  bfcrm_out_if res ();

  bale_flake_counter_rate_meter_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (smp.sink),
    .out_o  (res.source)
  );

  // --------------------------------------------------------------------------
  // Bench copy of the counter state, advanced on every accepted sample
  // --------------------------------------------------------------------------
  logic                  bale_prev;
  logic                  flake_prev;
  logic [COUNT_BITS-1:0] bales_cnt;
  logic [COUNT_BITS-1:0] year_cnt;
  logic [FLAKE_BITS-1:0] flakes_cur;
  logic [FLAKE_BITS-1:0] flakes_prev1;
  logic [FLAKE_BITS-1:0] flakes_prev2;
  logic [SESS_BITS-1:0]  sess_count;
  logic [TIME_BITS-1:0]  sess_first_ms;
  logic [TIME_BITS-1:0]  sess_latest_ms;
  logic [RATE_BITS-1:0]  rate_now;

  tally_t tallies_due[$];
  int unsigned error_count;
  int unsigned results_seen;
  int unsigned cycle_count;

  // Stimulus side state
  sink_mode_e           sink_mode;
  logic                 hold_request;
  bit                   gaps_on;
  int                   burst_left;
  logic [TIME_BITS-1:0] gen_time;
  logic                 gen_bale;
  logic                 gen_flake;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  // Rate in tenths of a bale per hour over the current session; zero for a
  // session of one bale or less and for zero elapsed time, clamped at the top.
  function automatic logic [RATE_BITS-1:0] expected_rate();
    logic [TIME_BITS-1:0] elapsed;
    logic [63:0]          quot;
    if (sess_count <= 1) return '0;
    elapsed = sess_latest_ms - sess_first_ms;
    if (elapsed == '0) return '0;
    quot = ({32'd0, sess_count - 32'd1} * TENTHS_MS_PER_HOUR) / {32'd0, elapsed};
    return (quot > 64'd65535) ? '1 : quot[RATE_BITS-1:0];
  endfunction

  task automatic reset_counters();
    bale_prev      = 1'b1;
    flake_prev     = 1'b1;
    bales_cnt      = '0;
    year_cnt       = '0;
    flakes_cur     = '0;
    flakes_prev1   = '0;
    flakes_prev2   = '0;
    sess_count     = '0;
    sess_first_ms  = '0;
    sess_latest_ms = '0;
    rate_now       = '0;
  endtask

  // Clears first, then the bale edge, then the flake edge.
  task automatic advance_counters(input sample_t s, output tally_t t);
    t = '0;
    if (s.clear_bale) begin
      bales_cnt      = '0;
      sess_count     = '0;
      sess_first_ms  = '0;
      sess_latest_ms = '0;
      rate_now       = '0;
    end
    if (s.clear_year) year_cnt = '0;
    if (s.clear_flakes) begin
      flakes_cur   = '0;
      flakes_prev1 = '0;
      flakes_prev2 = '0;
    end

    if (!bale_prev && s.bale_level) begin
      t.bale_seen = 1'b1;
      bales_cnt   = bales_cnt + 1'b1;
      year_cnt    = year_cnt + 1'b1;
      if (sess_count == '0) begin
        // first bale opens the session
        sess_first_ms = s.time_ms;
        sess_count    = 1;
        rate_now      = '0;
      end else begin
        if (sess_count != '1) sess_count = sess_count + 1'b1;
        sess_latest_ms = s.time_ms;
        rate_now       = expected_rate();
      end
      flakes_prev2 = flakes_prev1;
      flakes_prev1 = flakes_cur;
      flakes_cur   = '0;
    end
    bale_prev = s.bale_level;

    if (!flake_prev && s.flake_level) begin
      t.flake_seen = 1'b1;
      if (flakes_cur != '1) flakes_cur = flakes_cur + 1'b1;
    end
    flake_prev = s.flake_level;

    t.bale_total         = COUNT_OUT_W'(bales_cnt);
    t.bale_year_total    = COUNT_OUT_W'(year_cnt);
    t.flakes_now         = FLAKE_OUT_W'(flakes_cur);
    t.flakes_last        = FLAKE_OUT_W'(flakes_prev1);
    t.flakes_before_last = FLAKE_OUT_W'(flakes_prev2);
    t.rate_tenths        = rate_now;
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  // Print one line per failure (up to a cap) and count every one.
  task automatic flag_error(input string msg);
    if (error_count < MAX_PRINTED)
      $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("beat %0d %s: got 0x%0h, expected 0x%0h",
                           results_seen, name, got, want));
  endtask

  // Check result beats against the oldest expectation, then record the
  // expectation of any sample accepted at this edge. A result never leaves
  // in the cycle its sample enters, so the order within the edge is safe.
  always @(posedge clk_i) begin : scoreboard
    tally_t  got;
    tally_t  want;
    sample_t s;
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        got.bale_total         = res.bale_total;
        got.bale_year_total    = res.bale_year_total;
        got.flakes_now         = res.flakes_now;
        got.flakes_last        = res.flakes_last;
        got.flakes_before_last = res.flakes_before_last;
        got.rate_tenths        = res.rate_tenths;
        got.bale_seen          = res.bale_seen;
        got.flake_seen         = res.flake_seen;
        if (tallies_due.size() == 0) begin
          flag_error($sformatf("beat %0d arrived with nothing pending", results_seen));
        end else begin
          want = tallies_due.pop_front();
          compare_field("bale_total", got.bale_total, want.bale_total);
          compare_field("bale_year_total", got.bale_year_total, want.bale_year_total);
          compare_field("flakes_now", 32'(got.flakes_now), 32'(want.flakes_now));
          compare_field("flakes_last", 32'(got.flakes_last), 32'(want.flakes_last));
          compare_field("flakes_before_last", 32'(got.flakes_before_last),
                        32'(want.flakes_before_last));
          compare_field("rate_tenths", 32'(got.rate_tenths), 32'(want.rate_tenths));
          compare_field("bale_seen", 32'(got.bale_seen), 32'(want.bale_seen));
          compare_field("flake_seen", 32'(got.flake_seen), 32'(want.flake_seen));
        end
        results_seen++;
      end
      if (smp.valid && smp.ready) begin
        s.bale_level   = smp.bale_level;
        s.flake_level  = smp.flake_level;
        s.time_ms      = smp.time_ms;
        s.clear_bale   = smp.clear_bale;
        s.clear_year   = smp.clear_year;
        s.clear_flakes = smp.clear_flakes;
        advance_counters(s, want);
        tallies_due.push_back(want);
      end
    end
  end

  // Hard stop if the run hangs
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver pacing: at most one assignment to ready per edge. A hold request drops
  // ready for a long stretch counted here, so the block backs up into its
  // input channel.
  // --------------------------------------------------------------------------
  initial begin : sink_pacing
    int unsigned tick;
    tick = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_request) begin
        hold_request = 1'b0;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        case (sink_mode)
          SINK_FREE:    res.ready <= 1'b1;
          SINK_RANDOM:  res.ready <= ($urandom_range(0, 3) != 0);
          SINK_PATTERN: res.ready <= ((tick % 7) >= 3);
          SINK_HEAVY:   res.ready <= ($urandom_range(0, 9) < 3);
          default:      res.ready <= 1'b1;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  function automatic sample_t sensor_sample(input logic bale, input logic flake,
                                            input logic [TIME_BITS-1:0] t_ms,
                                            input logic cb, input logic cy,
                                            input logic cf);
    sample_t s;
    s.bale_level   = bale;
    s.flake_level  = flake;
    s.time_ms      = t_ms;
    s.clear_bale   = cb;
    s.clear_year   = cy;
    s.clear_flakes = cf;
    return s;
  endfunction

  // Offer one beat and hold it until accepted. Valid stays high on return so
  // back-to-back beats never lower and raise it within one time step; a gap
  // between bursts drops it first.
  task automatic offer_sample(input sample_t s);
    int unsigned gap;
    if (gaps_on) begin
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(1, 12);
        smp.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left--;
    end
    smp.valid        <= 1'b1;
    smp.bale_level   <= s.bale_level;
    smp.flake_level  <= s.flake_level;
    smp.time_ms      <= s.time_ms;
    smp.clear_bale   <= s.clear_bale;
    smp.clear_year   <= s.clear_year;
    smp.clear_flakes <= s.clear_flakes;
    @(posedge clk_i);
    while (!smp.ready) @(posedge clk_i);
  endtask

  // Pause the sender until every pending result has been taken.
  task automatic drain_results();
    smp.valid <= 1'b0;
    do @(posedge clk_i); while (tallies_due.size() != 0);
    burst_left = 0;
  endtask

  // Mostly plausible sensor traffic: advancing time, toggling levels, rare
  // clears. A slice of pure noise keeps odd combinations in the mix.
  function automatic sample_t next_sensor_sample();
    sample_t     s;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      s = sensor_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 10)      gen_time = gen_time;
      else if (pick < 40) gen_time = gen_time + $urandom_range(1, 40);
      else if (pick < 95) gen_time = gen_time + $urandom_range(50, 1500);
      else                gen_time = gen_time + $urandom_range(100000, 4000000);
      if ($urandom_range(0, 99) < 35) gen_bale = ~gen_bale;
      if ($urandom_range(0, 99) < 50) gen_flake = ~gen_flake;
      s = sensor_sample(gen_bale, gen_flake, gen_time,
                        $urandom_range(0, 99) < 2, $urandom_range(0, 99) < 2,
                        $urandom_range(0, 99) < 3);
    end
    gen_bale  = s.bale_level;
    gen_flake = s.flake_level;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Hand-picked samples: field extremes, every clear, both edges at once,
  // first bale of a session, zero elapsed time, rate clamp, clears landing
  // together with edges, and a session that spans the timestamp wrap.
  task automatic test_directed();
    sink_mode  = SINK_RANDOM;
    gaps_on    = 1'b1;
    burst_left = 0;
    offer_sample(sensor_sample(1, 1, 32'h0000_0000, 0, 0, 0));  // idle
    offer_sample(sensor_sample(0, 0, 32'h0000_0000, 0, 0, 0));  // both pressed
    offer_sample(sensor_sample(1, 1, 32'hFFFF_FFFF, 0, 0, 0));  // both edges, session opens
    offer_sample(sensor_sample(0, 1, 32'h0000_0000, 0, 0, 0));
    offer_sample(sensor_sample(1, 1, 32'd2000, 0, 0, 0));       // elapsed across the wrap
    offer_sample(sensor_sample(0, 1, 32'd2000, 0, 0, 0));
    offer_sample(sensor_sample(1, 1, 32'd2000, 0, 0, 0));
    offer_sample(sensor_sample(0, 1, 32'd2001, 1, 0, 0));       // clear the session alone
    offer_sample(sensor_sample(1, 1, 32'd5000, 0, 0, 0));       // first bale of new session
    offer_sample(sensor_sample(0, 1, 32'd5000, 0, 0, 0));
    offer_sample(sensor_sample(1, 1, 32'd5000, 0, 0, 0));       // zero elapsed
    offer_sample(sensor_sample(0, 1, 32'd5001, 0, 0, 0));
    offer_sample(sensor_sample(1, 1, 32'd5001, 0, 0, 0));       // 1 ms: rate clamps
    offer_sample(sensor_sample(0, 0, 32'd5001, 0, 0, 0));
    offer_sample(sensor_sample(1, 1, 32'd5002, 1, 0, 1));       // clears with both edges
    offer_sample(sensor_sample(0, 0, 32'd6000, 0, 1, 0));
    offer_sample(sensor_sample(1, 1, 32'd6000, 0, 1, 1));       // year clear with edges
    offer_sample(sensor_sample(0, 0, 32'h8000_0000, 0, 0, 0));
    offer_sample(sensor_sample(1, 0, 32'h8000_0000, 0, 0, 0));  // bale edge only
    offer_sample(sensor_sample(1, 1, 32'h8000_0001, 0, 0, 0));  // flake edge only
    offer_sample(sensor_sample(0, 1, 32'h8000_0001, 0, 0, 0));
    offer_sample(sensor_sample(1, 1, 32'h8036_EE80, 0, 0, 0));  // exactly one hour later
    offer_sample(sensor_sample(1, 1, 32'hFFFF_FFFF, 1, 1, 1));  // all clears, no edge
    offer_sample(sensor_sample(0, 1, 32'h0000_0000, 0, 0, 0));
    offer_sample(sensor_sample(1, 1, 32'h0000_0000, 0, 0, 0));
    drain_results();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering;
  // the block fills and stalls its input. Then the sender waits for all.
  task automatic test_back_pressure();
    sink_mode    = SINK_FREE;
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    repeat (12) offer_sample(next_sensor_sample());
    drain_results();
  endtask

  task automatic test_random_traffic(input int unsigned count, input sink_mode_e mode,
                                     input bit with_gaps);
    sink_mode  = mode;
    gaps_on    = with_gaps;
    burst_left = 0;
    for (int unsigned i = 0; i < count; i++) begin
      offer_sample(next_sensor_sample());
      if (i % 150 == 149) drain_results();
    end
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : run
    error_count  = 0;
    results_seen = 0;
    cycle_count  = 0;
    hold_request = 1'b0;
    sink_mode    = SINK_FREE;
    gaps_on      = 1'b0;
    burst_left   = 0;
    gen_time     = 32'hFFFF_0000;  // start near the top so the clock wraps
    gen_bale     = 1'b1;
    gen_flake    = 1'b1;
    reset_counters();

    rst_ni           <= 1'b0;
    smp.valid        <= 1'b0;
    smp.bale_level   <= 1'b1;
    smp.flake_level  <= 1'b1;
    smp.time_ms      <= '0;
    smp.clear_bale   <= 1'b0;
    smp.clear_year   <= 1'b0;
    smp.clear_flakes <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_back_pressure();
    test_random_traffic(400, SINK_RANDOM, 1'b1);
    test_random_traffic(300, SINK_FREE, 1'b0);
    test_random_traffic(350, SINK_PATTERN, 1'b1);
    test_random_traffic(260, SINK_HEAVY, 1'b1);

    // Everything is in; let any straggler show up before the verdict
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && tallies_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
